// ===== src/point_query_bound_finder_top_defines.svh =====
// Assertion macros shared by the point query bound finder checkers.
// Depends on nothing; included by the checker file only.
`ifndef POINT_QUERY_BOUND_FINDER_TOP_DEFINES_SVH
`define POINT_QUERY_BOUND_FINDER_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define PQBF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define PQBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pqbf_pkg.sv =====
// Shared types and constants of the point query bound finder.
// Depends on nothing; used by every RTL module of the block.
package pqbf_pkg;

    // Default sizes
    localparam int KEY_COLUMNS_DEF    = 8;
    localparam int TUPLE_COLUMNS_DEF  = 16;
    localparam int MAX_PREDICATES_DEF = 64;
    localparam int QUEUE_DEPTH        = 2;

    // Field widths
    localparam int MAP_ENTRY_W  = 4;
    localparam int KEY_OUT_W    = 3;
    localparam int POS_OUT_W    = 6;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 24;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 64;

    // Comparison kind codes
    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_GT = 3'd1;
    localparam logic [2:0] CMP_GE = 3'd2;
    localparam logic [2:0] CMP_LT = 3'd3;
    localparam logic [2:0] CMP_LE = 3'd4;

    // Register select (paddr bit 3)
    localparam logic REG_KEY_COUNT  = 1'b0;
    localparam logic REG_COLUMN_MAP = 1'b1;

    // Classified predicate handed from front to back
    typedef struct packed {
        logic [MAP_ENTRY_W-1:0] key_col;
        logic                   lower_kind;
        logic                   upper_kind;
        logic                   map_err;
        logic                   last;
    } t_op;

    // One result word
    typedef struct packed {
        logic                 error_seen;
        logic                 point_query;
        logic                 upper_found;
        logic [POS_OUT_W-1:0] upper_position;
        logic                 lower_found;
        logic [POS_OUT_W-1:0] lower_position;
        logic [KEY_OUT_W-1:0] key_column;
        logic                 last_result;
    } t_result;

endpackage

// ===== src/pqbf_queue.sv =====
// Short FIFO of classified predicates between front and back.
// Depends on pqbf_pkg (t_op).
module pqbf_queue #(
    parameter int DEPTH = pqbf_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pqbf_pkg::t_op  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output pqbf_pkg::t_op  o_data,
    output logic           o_empty
);
    import pqbf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/pqbf_front.sv =====
// Front part: maps a predicate's tuple column to a key column and decodes its bounds.
// Depends on pqbf_pkg (t_op, comparison codes).
module pqbf_front #(
    parameter int KEY_COLUMNS   = pqbf_pkg::KEY_COLUMNS_DEF,
    parameter int TUPLE_COLUMNS = pqbf_pkg::TUPLE_COLUMNS_DEF
) (
    input  logic [3:0]                       i_tuple_column,
    input  logic [2:0]                       i_compare_kind,
    input  logic                             i_last_predicate,
    input  logic [63:0]                      i_column_map,
    input  logic [$clog2(KEY_COLUMNS+1)-1:0] i_keys,
    output pqbf_pkg::t_op                    o_op
);
    import pqbf_pkg::*;

    logic [MAP_ENTRY_W-1:0] w_key_col;
    logic                   w_lower;
    logic                   w_upper;

    // Look up the key column of this tuple column
    assign w_key_col = i_column_map[MAP_ENTRY_W * i_tuple_column +: MAP_ENTRY_W];

    // Decode which bounds the comparison gives
    always_comb begin
        w_lower = 1'b0;
        w_upper = 1'b0;
        case (i_compare_kind) inside
            CMP_EQ:         begin w_lower = 1'b1; w_upper = 1'b1; end
            CMP_GT, CMP_GE: w_lower = 1'b1;
            CMP_LT, CMP_LE: w_upper = 1'b1;
            default:        ;
        endcase
    end

    // Flag tuple columns beyond the table and map entries beyond the key count
    assign o_op.key_col    = w_key_col;
    assign o_op.lower_kind = w_lower;
    assign o_op.upper_kind = w_upper;
    assign o_op.map_err    = (5'(i_tuple_column) >= 5'(TUPLE_COLUMNS))
                           || (5'(w_key_col) >= 5'(i_keys));
    assign o_op.last       = i_last_predicate;

endmodule

// ===== src/pqbf_back.sv =====
// Back part: keeps the bound tables, point-query count and error flag, drains results.
// Depends on pqbf_pkg (t_op, t_result).
module pqbf_back #(
    parameter int KEY_COLUMNS    = pqbf_pkg::KEY_COLUMNS_DEF,
    parameter int MAX_PREDICATES = pqbf_pkg::MAX_PREDICATES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(KEY_COLUMNS+1)-1:0] i_keys,
    input  pqbf_pkg::t_op                    i_op,
    input  logic                             i_op_valid,
    output logic                             o_op_pop,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output pqbf_pkg::t_result                o_res
);
    import pqbf_pkg::*;

    localparam int KC_W   = $clog2(KEY_COLUMNS + 1);
    localparam int KIDX_W = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1;
    localparam int CNT_W  = $clog2(MAX_PREDICATES + 1);

    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_lower_pos [KEY_COLUMNS];
    logic [CNT_W-1:0]        r_upper_pos [KEY_COLUMNS];
    logic [KEY_COLUMNS-1:0]  r_lower_vld;
    logic [KEY_COLUMNS-1:0]  r_upper_vld;
    logic [3:0]              r_eq_count;
    logic [3:0]              n_eq_count;
    logic                    r_point_done;
    logic [CNT_W-1:0]        r_pos;
    logic                    r_error;
    logic [KIDX_W-1:0]       r_drain_idx;
    logic                    r_out_valid;
    t_result                 r_out;

    logic [KIDX_W-1:0]       w_addr;
    logic [CNT_W-1:0]        w_lpos;
    logic [CNT_W-1:0]        w_upos;
    logic                    w_lv;
    logic                    w_uv;
    logic                    w_pos_ok;
    logic                    w_apply;
    logic                    w_set_lower;
    logic                    w_set_upper;
    logic                    w_eq_hit;
    logic                    w_slot_free;
    logic                    w_load;
    logic                    w_final;

    // Share one table read port between update and drain
    assign w_addr = (r_state == S_DRAIN) ? r_drain_idx : i_op.key_col[KIDX_W-1:0];
    assign w_lpos = r_lower_pos[w_addr];
    assign w_upos = r_upper_pos[w_addr];
    assign w_lv   = r_lower_vld[w_addr];
    assign w_uv   = r_upper_vld[w_addr];

    // Decide what the popped predicate records
    assign o_op_pop    = (r_state == S_RUN) && i_op_valid;
    assign w_pos_ok    = (r_pos < CNT_W'(MAX_PREDICATES));
    assign w_apply     = o_op_pop && !r_point_done && w_pos_ok && !i_op.map_err;
    assign w_set_lower = w_apply && i_op.lower_kind && !w_lv;
    assign w_set_upper = w_apply && i_op.upper_kind && !w_uv;
    assign w_eq_hit    = w_set_upper && (w_set_lower || (w_lv && (w_lpos == r_pos)));
    assign n_eq_count  = r_eq_count + 4'd1;

    // Output slot handling during drain
    assign w_slot_free = !r_out_valid || i_res_ready;
    assign w_load      = (r_state == S_DRAIN) && w_slot_free;
    assign w_final     = (KC_W'(r_drain_idx) + KC_W'(1)) == i_keys;

    // Control state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_lower_vld  <= '0;
            r_upper_vld  <= '0;
            r_eq_count   <= '0;
            r_point_done <= 1'b0;
            r_pos        <= '0;
            r_error      <= 1'b0;
            r_drain_idx  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            unique case (r_state)
                S_RUN: begin
                    if (r_out_valid && i_res_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (o_op_pop) begin
                        if (w_pos_ok) begin
                            r_pos <= r_pos + 1'b1;
                        end
                        if (!r_point_done && (!w_pos_ok || i_op.map_err)) begin
                            r_error <= 1'b1;
                        end
                        if (w_set_lower) begin
                            r_lower_vld[w_addr] <= 1'b1;
                        end
                        if (w_set_upper) begin
                            r_upper_vld[w_addr] <= 1'b1;
                        end
                        if (w_eq_hit) begin
                            r_eq_count <= n_eq_count;
                            if (5'(n_eq_count) == 5'(i_keys)) begin
                                r_point_done <= 1'b1;
                            end
                        end
                        if (i_op.last) begin
                            r_state     <= S_DRAIN;
                            r_drain_idx <= '0;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        if (w_final) begin
                            // Clear the query state for the next run
                            r_lower_vld  <= '0;
                            r_upper_vld  <= '0;
                            r_eq_count   <= '0;
                            r_point_done <= 1'b0;
                            r_pos        <= '0;
                            r_error      <= 1'b0;
                            r_state      <= S_RUN;
                        end else begin
                            r_drain_idx <= r_drain_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    // Record bound positions
    always_ff @(posedge i_clk) begin
        if (w_set_lower) begin
            r_lower_pos[w_addr] <= r_pos;
        end
        if (w_set_upper) begin
            r_upper_pos[w_addr] <= r_pos;
        end
    end

    // Build the result word for the key column under drain
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.key_column     <= KEY_OUT_W'(r_drain_idx);
            r_out.lower_position <= w_lv ? POS_OUT_W'(w_lpos) : '0;
            r_out.lower_found    <= w_lv;
            r_out.upper_position <= w_uv ? POS_OUT_W'(w_upos) : '0;
            r_out.upper_found    <= w_uv;
            r_out.point_query    <= r_point_done;
            r_out.error_seen     <= r_error;
            r_out.last_result    <= w_final;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== src/point_query_bound_finder_top.sv =====
// Top level of the point query bound finder: configuration registers, stream ports,
// and the front, queue and back parts. Depends on pqbf_pkg and the three submodules.
//
// Predicates enter on the s_axis side, one word each, and are mapped to key columns
// by the front part as they arrive; a two-entry queue feeds the back part, which
// records one predicate per cycle outside the drain, so a query runs at one predicate
// per clock. The word marked tlast makes the back part emit one result per used key
// column (key column 0 first, m_axis_tlast on the final one); the drain stalls while
// m_axis_tready is low, and during it the back part records no new predicate, so the
// input takes at most the two queue entries. The user must write the key count and
// column map over the APB port (key count at 0x0, map at 0x8) only while no query is
// in progress, unchecked by the block, which leaves reset ready without a clearing pass.
module point_query_bound_finder_top #(
    parameter int KEY_COLUMNS    = pqbf_pkg::KEY_COLUMNS_DEF,
    parameter int TUPLE_COLUMNS  = pqbf_pkg::TUPLE_COLUMNS_DEF,
    parameter int MAX_PREDICATES = pqbf_pkg::MAX_PREDICATES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pqbf_pkg::PADDR_W-1:0]   paddr,
    input  logic [pqbf_pkg::PDATA_W-1:0]   pwdata,
    output logic [pqbf_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    // Predicate input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pqbf_pkg::S_TDATA_W-1:0] s_axis_tdata,  // tuple_column[3:0], compare_kind[6:4]
    input  logic                           s_axis_tlast,  // last_predicate
    // Result output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // key_column[2:0], lower_position[8:3], lower_found[9], upper_position[15:10],
    // upper_found[16], point_query[17], error_seen[18]
    output logic [pqbf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast   // last_result
);
    import pqbf_pkg::*;

    localparam int KC_W = $clog2(KEY_COLUMNS + 1);

    logic [3:0]      r_key_count;
    logic [63:0]     r_column_map;
    logic            w_cfg_write;
    logic [KC_W-1:0] w_keys;
    t_op             w_front_op;
    t_op             w_queue_op;
    logic            w_queue_full;
    logic            w_queue_empty;
    logic            w_pop;
    logic            w_res_valid;
    t_result         w_res;

    // Write configuration registers on the access cycle
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count  <= 4'd1;
            r_column_map <= '0;
        end else if (w_cfg_write) begin
            unique case (paddr[3])
                REG_KEY_COUNT:  r_key_count  <= pwdata[3:0];
                REG_COLUMN_MAP: r_column_map <= pwdata;
                default:        ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[3])
            REG_KEY_COUNT:  prdata = {60'd0, r_key_count};
            REG_COLUMN_MAP: prdata = r_column_map;
            default:        prdata = '0;
        endcase
    end

    // Clamp the key count to one through KEY_COLUMNS
    always_comb begin
        if (r_key_count == 4'd0) begin
            w_keys = KC_W'(1);
        end else if (5'(r_key_count) > 5'(KEY_COLUMNS)) begin
            w_keys = KC_W'(KEY_COLUMNS);
        end else begin
            w_keys = KC_W'(r_key_count);
        end
    end

    pqbf_front #(
        .KEY_COLUMNS   (KEY_COLUMNS),
        .TUPLE_COLUMNS (TUPLE_COLUMNS)
    ) u_front (
        .i_tuple_column   (s_axis_tdata[3:0]),
        .i_compare_kind   (s_axis_tdata[6:4]),
        .i_last_predicate (s_axis_tlast),
        .i_column_map     (r_column_map),
        .i_keys           (w_keys),
        .o_op             (w_front_op)
    );

    assign s_axis_tready = !w_queue_full;

    pqbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (w_front_op),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_data  (w_queue_op),
        .o_empty (w_queue_empty)
    );

    pqbf_back #(
        .KEY_COLUMNS    (KEY_COLUMNS),
        .MAX_PREDICATES (MAX_PREDICATES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_keys      (w_keys),
        .i_op        (w_queue_op),
        .i_op_valid  (!w_queue_empty),
        .o_op_pop    (w_pop),
        .o_res_valid (w_res_valid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    // Pack the result word
    assign m_axis_tvalid = w_res_valid;
    assign m_axis_tlast  = w_res.last_result;
    assign m_axis_tdata  = {5'd0, w_res.error_seen, w_res.point_query, w_res.upper_found,
                            w_res.upper_position, w_res.lower_found, w_res.lower_position,
                            w_res.key_column};

endmodule

// ===== src/pqbf_checker.sv =====
// Port-level checks of the point query bound finder, bound to the top level.
// Depends on point_query_bound_finder_top_defines.svh.
`include "point_query_bound_finder_top_defines.svh"

module pqbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result word holds
    `PQBF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // Results of one query follow without a gap, key column by key column
    `PQBF_ASSERT_NEXT(a_drain_step, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[2:0] == $past(m_axis_tdata[2:0]) + 3'd1), "drain skipped or repeated a key column")

    // Query-wide flags agree across one query's results
    `PQBF_ASSERT_NEXT(a_flags_const, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tdata[18:17] == $past(m_axis_tdata[18:17]), "query flags changed within a query")

    // Missing bounds report position zero
    `PQBF_ASSERT_SAME(a_bound_zero, i_clk, i_rst_n, m_axis_tvalid && (!m_axis_tdata[9] || !m_axis_tdata[16]), (m_axis_tdata[9] || (m_axis_tdata[8:3] == 6'd0)) && (m_axis_tdata[16] || (m_axis_tdata[15:10] == 6'd0)), "unfound bound with nonzero position")

endmodule

bind point_query_bound_finder_top pqbf_checker u_pqbf_checker (.*);
